@@ rtl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros.svh
// Clocked assertion shorthands, sampled on clk_i, off while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every enabled clock edge
`define VFA_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// expression must never be true
`define VFA_ASSERT_NEVER(name, expr, msg) \
  `VFA_ASSERT(name, !(expr), msg)

`endif

@@ rtl/vfa_pkg.sv @@
// ----------------------------------------------------------------------------
// vfa_pkg
// Shared types, opcodes and helpers of the fixed-point vector ALU.
// ----------------------------------------------------------------------------
package vfa_pkg;

  localparam int unsigned FracBitsDefault = 16;
  // |a| shifted left by up to 24 fraction bits
  localparam int unsigned DividendW = 56;
  localparam int unsigned RootSteps = 32;
  localparam int unsigned QuotSteps = 32;

  localparam logic signed [31:0] S32Max = 32'sh7fff_ffff;
  localparam logic signed [31:0] S32Min = 32'sh8000_0000;

  typedef enum logic [3:0] {
    OP_ADD   = 4'd0,
    OP_SUB   = 4'd1,
    OP_MUL   = 4'd2,
    OP_DIV   = 4'd3,
    OP_SADD  = 4'd4,
    OP_SSUB  = 4'd5,
    OP_SMUL  = 4'd6,
    OP_SDIV  = 4'd7,
    OP_NEG   = 4'd8,
    OP_DOT   = 4'd9,
    OP_CROSS = 4'd10,
    OP_MAG   = 4'd11,
    OP_NORM  = 4'd12,
    OP_DIST  = 4'd13,
    OP_EQ    = 4'd14,
    OP_SUM   = 4'd15
  } op_e;

  typedef struct packed {
    logic [3:0]         op;
    logic signed [31:0] a_x;
    logic signed [31:0] a_y;
    logic signed [31:0] a_z;
    logic signed [31:0] b_x;
    logic signed [31:0] b_y;
    logic signed [31:0] b_z;
    logic signed [31:0] scalar_in;
  } req_t;

  typedef struct packed {
    logic signed [31:0] r_x;
    logic signed [31:0] r_y;
    logic signed [31:0] r_z;
    logic signed [31:0] scalar_out;
    logic               equal_flag;
    logic               saturated_flag;
    logic               divide_by_zero;
  } rsp_t;

  typedef logic [2:0][31:0] vec_t;

  // per-request results and sign info riding along the pipeline
  typedef struct packed {
    op_e        op;
    vec_t       vec;
    logic [31:0] s;
    logic       eq;
    logic       sat;
    logic [2:0] qneg;
    logic [2:0] aneg;
    logic [2:0] azero;
    logic [2:0] dzl;
  } ctl_t;

  typedef struct packed {
    ctl_t                      ctl;
    logic [2:0][DividendW-1:0] n;
    vec_t                      dvs;
  } sq_side_t;

  typedef struct packed {
    logic        sat;
    logic [31:0] val;
  } sat_t;

  function automatic sat_t sat66(logic signed [65:0] v);
    sat_t r;
    r.sat = 1'b1;
    if (v > 66'(S32Max)) begin
      r.val = S32Max;
    end else if (v < 66'(S32Min)) begin
      r.val = S32Min;
    end else begin
      r.sat = 1'b0;
      r.val = v[31:0];
    end
    return r;
  endfunction

endpackage

@@ rtl/vfa_sqrt.sv @@
// ----------------------------------------------------------------------------
// vfa_sqrt
// Pipelined floor square root of a 64-bit radicand, one root bit per stage.
// ----------------------------------------------------------------------------
module vfa_sqrt (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic               valid_i,
  input  logic [63:0]        rad_i,
  input  vfa_pkg::sq_side_t  side_i,
  output logic               valid_o,
  output logic [31:0]        root_o,
  output vfa_pkg::sq_side_t  side_o
);
  import vfa_pkg::*;

  logic        v_q    [RootSteps];
  logic [32:0] rem_q  [RootSteps];
  logic [31:0] root_q [RootSteps];
  logic [63:0] rad_q  [RootSteps];
  sq_side_t    side_q [RootSteps];

  for (genvar k = 0; k < RootSteps; k++) begin : g_step
    logic        v_in;
    logic [32:0] rem_in;
    logic [31:0] root_in;
    logic [63:0] rad_in;
    sq_side_t    side_in;
    logic [34:0] cur;
    logic [34:0] trial;
    logic [34:0] diff;
    logic        fit;

    if (k == 0) begin : g_first
      assign v_in    = valid_i;
      assign rem_in  = '0;
      assign root_in = '0;
      assign rad_in  = rad_i;
      assign side_in = side_i;
    end else begin : g_next
      assign v_in    = v_q[k-1];
      assign rem_in  = rem_q[k-1];
      assign root_in = root_q[k-1];
      assign rad_in  = rad_q[k-1];
      assign side_in = side_q[k-1];
    end

    assign cur   = {rem_in, rad_in[63:62]};
    assign trial = {1'b0, root_in, 2'b01};
    assign fit   = (cur >= trial);
    assign diff  = cur - trial;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else if (en_i) begin
        v_q[k] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k]  <= fit ? diff[32:0] : cur[32:0];
        root_q[k] <= {root_in[30:0], fit};
        rad_q[k]  <= {rad_in[61:0], 2'b00};
        side_q[k] <= side_in;
      end
    end
  end

  assign valid_o = v_q[RootSteps-1];
  assign root_o  = root_q[RootSteps-1];
  assign side_o  = side_q[RootSteps-1];

endmodule

@@ rtl/vfa_div3.sv @@
// ----------------------------------------------------------------------------
// vfa_div3
// Three-lane pipelined restoring divider, 56-bit dividend by 32-bit divisor,
// one quotient bit per stage, with a quotient overflow flag per lane.
// ----------------------------------------------------------------------------
module vfa_div3 (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               en_i,
  input  logic                               valid_i,
  input  logic [2:0][vfa_pkg::DividendW-1:0] n_i,
  input  vfa_pkg::vec_t                      d_i,
  input  vfa_pkg::ctl_t                      ctl_i,
  output logic                               valid_o,
  output vfa_pkg::vec_t                      q_o,
  output logic [2:0]                         ov_o,
  output vfa_pkg::ctl_t                      ctl_o
);
  import vfa_pkg::*;

  logic       v0_q;
  vec_t       rem0_q;
  vec_t       low0_q;
  vec_t       d0_q;
  logic [2:0] ov0_q;
  ctl_t       ctl0_q;

  logic       v_q   [QuotSteps];
  vec_t       rem_q [QuotSteps];
  vec_t       low_q [QuotSteps];
  vec_t       d_q   [QuotSteps];
  logic [2:0] ov_q  [QuotSteps];
  ctl_t       ctl_q [QuotSteps];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
    end else if (en_i) begin
      v0_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < 3; i++) begin
        rem0_q[i] <= 32'(n_i[i][DividendW-1:32]);
        low0_q[i] <= n_i[i][31:0];
        ov0_q[i]  <= (32'(n_i[i][DividendW-1:32]) >= d_i[i]);
      end
      d0_q   <= d_i;
      ctl0_q <= ctl_i;
    end
  end

  for (genvar k = 0; k < QuotSteps; k++) begin : g_step
    logic            v_in;
    vec_t            rem_in;
    vec_t            low_in;
    vec_t            d_in;
    logic [2:0]      ov_in;
    ctl_t            ctl_in;
    logic [2:0][32:0] cur;
    logic [2:0][32:0] diff;
    logic [2:0]      fit;
    vec_t            rem_nx;
    vec_t            low_nx;

    if (k == 0) begin : g_first
      assign v_in   = v0_q;
      assign rem_in = rem0_q;
      assign low_in = low0_q;
      assign d_in   = d0_q;
      assign ov_in  = ov0_q;
      assign ctl_in = ctl0_q;
    end else begin : g_next
      assign v_in   = v_q[k-1];
      assign rem_in = rem_q[k-1];
      assign low_in = low_q[k-1];
      assign d_in   = d_q[k-1];
      assign ov_in  = ov_q[k-1];
      assign ctl_in = ctl_q[k-1];
    end

    always_comb begin
      for (int i = 0; i < 3; i++) begin
        cur[i]    = {rem_in[i], low_in[i][31]};
        diff[i]   = cur[i] - {1'b0, d_in[i]};
        fit[i]    = (cur[i] >= {1'b0, d_in[i]});
        rem_nx[i] = fit[i] ? diff[i][31:0] : cur[i][31:0];
        low_nx[i] = {low_in[i][30:0], fit[i]};
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else if (en_i) begin
        v_q[k] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k] <= rem_nx;
        low_q[k] <= low_nx;
        d_q[k]   <= d_in;
        ov_q[k]  <= ov_in;
        ctl_q[k] <= ctl_in;
      end
    end
  end

  assign valid_o = v_q[QuotSteps-1];
  assign q_o     = low_q[QuotSteps-1];
  assign ov_o    = ov_q[QuotSteps-1];
  assign ctl_o   = ctl_q[QuotSteps-1];

endmodule

@@ rtl/vector3_fixed_point_alu_core.sv @@
// ----------------------------------------------------------------------------
// vector3_fixed_point_alu_core
// Throughput: one request per cycle while the output skid is empty; the
// 32-stage root pipeline and the 33-stage divide pipeline are fully
// pipelined, so no op repeats a unit.
// A one-entry output skid holds a stalled result; input ready is low while it is full.
// Reset: asynchronous, active low; clears all valid bits, payload is not reset.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module vector3_fixed_point_alu_core #(
  parameter int unsigned FracBits = vfa_pkg::FracBitsDefault
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  vfa_pkg::req_t in_req_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output vfa_pkg::rsp_t out_rsp_o
);
  import vfa_pkg::*;

  logic en;
  logic in_scl;

  // stage 1: operands
  logic               s1_v_q;
  op_e                s1_op_q;
  logic signed [31:0] s1_a_q [3];
  logic signed [31:0] s1_b_q [3];

  // stage 2: add, sub, neg, sum, compare
  logic                      s2_v_q;
  ctl_t                      s2_ctl_q;
  logic [2:0][DividendW-1:0] s2_n_q;
  vec_t                      s2_dvs_q;
  logic signed [31:0]        s2_a_q  [3];
  logic signed [31:0]        s2_b_q  [3];
  logic signed [31:0]        s2_sq_q [3];

  ctl_t                      ctl2_d;
  logic [2:0][DividendW-1:0] n2_d;
  vec_t                      dvs2_d;
  logic signed [31:0]        sq2_d [3];
  sat_t                      add_s [3];
  sat_t                      sub_s [3];
  sat_t                      neg_s [3];
  sat_t                      tot_s;
  logic [31:0]               absa  [3];
  logic                      is_div1;

  // stage 3: products
  logic                      s3_v_q;
  ctl_t                      s3_ctl_q;
  logic [2:0][DividendW-1:0] s3_n_q;
  vec_t                      s3_dvs_q;
  logic signed [63:0]        s3_ab_q [3];
  logic signed [63:0]        s3_cr_q [6];
  logic signed [63:0]        s3_sq_q [3];

  // stage 4: product sums
  logic                      s4_v_q;
  ctl_t                      s4_ctl_q;
  logic [2:0][DividendW-1:0] s4_n_q;
  vec_t                      s4_dvs_q;
  logic signed [63:0]        s4_ab_q [3];
  logic signed [65:0]        s4_dot_q;
  logic signed [65:0]        s4_cr_q [3];
  logic [63:0]               s4_sqs_q;

  // stage 5: shift and saturate
  logic                      s5_v_q;
  ctl_t                      s5_ctl_q;
  logic [2:0][DividendW-1:0] s5_n_q;
  vec_t                      s5_dvs_q;
  logic [63:0]               s5_rad_q;
  ctl_t                      ctl5_d;
  sat_t                      mul_s [3];
  sat_t                      cr_s  [3];
  sat_t                      dot_s;
  sq_side_t                  s5_side;

  // root pipeline
  logic        sq_v;
  logic [31:0] sq_root;
  sq_side_t    sq_side;

  // post-root stage
  logic                      p_v_q;
  ctl_t                      p_ctl_q;
  logic [2:0][DividendW-1:0] p_n_q;
  vec_t                      p_dv_q;
  ctl_t                      ctlp_d;
  vec_t                      dvp_d;

  // divide pipeline
  logic       dv_v;
  vec_t       dv_q;
  logic [2:0] dv_ov;
  ctl_t       dv_ctl;

  // final stage and skid
  rsp_t rsp_d;
  vec_t fvec;
  logic fsat;
  logic fdz;
  logic last_v_q;
  rsp_t last_q;
  logic skid_v_q;
  rsp_t skid_q;

  assign en         = !skid_v_q;
  assign in_ready_o = en;

  // ---------------- stage 1 ----------------
  assign in_scl = (in_req_i.op == OP_SADD) || (in_req_i.op == OP_SSUB) ||
                  (in_req_i.op == OP_SMUL) || (in_req_i.op == OP_SDIV);

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_op_q   <= op_e'(in_req_i.op);
      s1_a_q[0] <= in_req_i.a_x;
      s1_a_q[1] <= in_req_i.a_y;
      s1_a_q[2] <= in_req_i.a_z;
      s1_b_q[0] <= in_scl ? in_req_i.scalar_in : in_req_i.b_x;
      s1_b_q[1] <= in_scl ? in_req_i.scalar_in : in_req_i.b_y;
      s1_b_q[2] <= in_scl ? in_req_i.scalar_in : in_req_i.b_z;
    end
  end

  // ---------------- stage 2 ----------------
  assign is_div1 = (s1_op_q == OP_DIV) || (s1_op_q == OP_SDIV);

  always_comb begin
    ctl2_d    = '0;
    ctl2_d.op = s1_op_q;
    tot_s     = sat66(66'(s1_a_q[0]) + 66'(s1_a_q[1]) + 66'(s1_a_q[2]));
    for (int i = 0; i < 3; i++) begin
      add_s[i] = sat66(66'(s1_a_q[i]) + 66'(s1_b_q[i]));
      sub_s[i] = sat66(66'(s1_a_q[i]) - 66'(s1_b_q[i]));
      neg_s[i] = sat66(66'sd0 - 66'(s1_a_q[i]));
      absa[i]  = s1_a_q[i][31] ? (~s1_a_q[i] + 32'd1) : s1_a_q[i];
      dvs2_d[i] = s1_b_q[i][31] ? (~s1_b_q[i] + 32'd1) : s1_b_q[i];
      n2_d[i]  = DividendW'(absa[i]) << FracBits;
      sq2_d[i] = (s1_op_q == OP_DIST) ? sub_s[i].val : s1_a_q[i];
      ctl2_d.aneg[i]  = s1_a_q[i][31];
      ctl2_d.azero[i] = (s1_a_q[i] == '0);
      ctl2_d.qneg[i]  = s1_a_q[i][31] ^ (is_div1 & s1_b_q[i][31]);
    end
    case (s1_op_q) inside
      OP_ADD, OP_SADD: begin
        for (int i = 0; i < 3; i++) ctl2_d.vec[i] = add_s[i].val;
        ctl2_d.sat = add_s[0].sat | add_s[1].sat | add_s[2].sat;
      end
      OP_SUB, OP_SSUB: begin
        for (int i = 0; i < 3; i++) ctl2_d.vec[i] = sub_s[i].val;
        ctl2_d.sat = sub_s[0].sat | sub_s[1].sat | sub_s[2].sat;
      end
      OP_NEG: begin
        for (int i = 0; i < 3; i++) ctl2_d.vec[i] = neg_s[i].val;
        ctl2_d.sat = neg_s[0].sat | neg_s[1].sat | neg_s[2].sat;
      end
      OP_DIST: ctl2_d.sat = sub_s[0].sat | sub_s[1].sat | sub_s[2].sat;
      OP_EQ: begin
        ctl2_d.eq = (s1_a_q[0] == s1_b_q[0]) && (s1_a_q[1] == s1_b_q[1]) &&
                    (s1_a_q[2] == s1_b_q[2]);
      end
      OP_SUM: begin
        ctl2_d.s   = tot_s.val;
        ctl2_d.sat = tot_s.sat;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s2_ctl_q <= ctl2_d;
      s2_n_q   <= n2_d;
      s2_dvs_q <= dvs2_d;
      s2_a_q   <= s1_a_q;
      s2_b_q   <= s1_b_q;
      s2_sq_q  <= sq2_d;
    end
  end

  // ---------------- stage 3 ----------------
  always_ff @(posedge clk_i) begin
    if (en) begin
      s3_ctl_q <= s2_ctl_q;
      s3_n_q   <= s2_n_q;
      s3_dvs_q <= s2_dvs_q;
      for (int i = 0; i < 3; i++) begin
        s3_ab_q[i] <= s2_a_q[i] * s2_b_q[i];
        s3_sq_q[i] <= s2_sq_q[i] * s2_sq_q[i];
      end
      s3_cr_q[0] <= s2_a_q[1] * s2_b_q[2];
      s3_cr_q[1] <= s2_a_q[2] * s2_b_q[1];
      s3_cr_q[2] <= s2_a_q[2] * s2_b_q[0];
      s3_cr_q[3] <= s2_a_q[0] * s2_b_q[2];
      s3_cr_q[4] <= s2_a_q[0] * s2_b_q[1];
      s3_cr_q[5] <= s2_a_q[1] * s2_b_q[0];
    end
  end

  // ---------------- stage 4 ----------------
  always_ff @(posedge clk_i) begin
    if (en) begin
      s4_ctl_q <= s3_ctl_q;
      s4_n_q   <= s3_n_q;
      s4_dvs_q <= s3_dvs_q;
      s4_ab_q  <= s3_ab_q;
      s4_dot_q <= 66'(s3_ab_q[0]) + 66'(s3_ab_q[1]) + 66'(s3_ab_q[2]);
      for (int i = 0; i < 3; i++) begin
        s4_cr_q[i] <= 66'(s3_cr_q[2*i]) - 66'(s3_cr_q[2*i+1]);
      end
      s4_sqs_q <= $unsigned(s3_sq_q[0]) + $unsigned(s3_sq_q[1]) + $unsigned(s3_sq_q[2]);
    end
  end

  // ---------------- stage 5 ----------------
  always_comb begin
    ctl5_d = s4_ctl_q;
    dot_s  = sat66(s4_dot_q >>> FracBits);
    for (int i = 0; i < 3; i++) begin
      mul_s[i] = sat66(66'(s4_ab_q[i]) >>> FracBits);
      cr_s[i]  = sat66(s4_cr_q[i] >>> FracBits);
    end
    case (s4_ctl_q.op) inside
      OP_MUL, OP_SMUL: begin
        for (int i = 0; i < 3; i++) ctl5_d.vec[i] = mul_s[i].val;
        ctl5_d.sat = mul_s[0].sat | mul_s[1].sat | mul_s[2].sat;
      end
      OP_CROSS: begin
        for (int i = 0; i < 3; i++) ctl5_d.vec[i] = cr_s[i].val;
        ctl5_d.sat = cr_s[0].sat | cr_s[1].sat | cr_s[2].sat;
      end
      OP_DOT: begin
        ctl5_d.s   = dot_s.val;
        ctl5_d.sat = dot_s.sat;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s5_ctl_q <= ctl5_d;
      s5_n_q   <= s4_n_q;
      s5_dvs_q <= s4_dvs_q;
      s5_rad_q <= s4_sqs_q;
    end
  end

  assign s5_side.ctl = s5_ctl_q;
  assign s5_side.n   = s5_n_q;
  assign s5_side.dvs = s5_dvs_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
      s3_v_q <= 1'b0;
      s4_v_q <= 1'b0;
      s5_v_q <= 1'b0;
      p_v_q  <= 1'b0;
    end else if (en) begin
      s1_v_q <= in_valid_i;
      s2_v_q <= s1_v_q;
      s3_v_q <= s2_v_q;
      s4_v_q <= s3_v_q;
      s5_v_q <= s4_v_q;
      p_v_q  <= sq_v;
    end
  end

  // ---------------- square root ----------------
  vfa_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (s5_v_q),
    .rad_i   (s5_rad_q),
    .side_i  (s5_side),
    .valid_o (sq_v),
    .root_o  (sq_root),
    .side_o  (sq_side)
  );

  // ---------------- post-root ----------------
  always_comb begin
    ctlp_d = sq_side.ctl;
    if ((ctlp_d.op == OP_MAG) || (ctlp_d.op == OP_DIST)) begin
      ctlp_d.s   = sq_root[31] ? S32Max : sq_root;
      ctlp_d.sat = ctlp_d.sat | sq_root[31];
    end
    for (int i = 0; i < 3; i++) begin
      dvp_d[i] = (ctlp_d.op == OP_NORM) ? sq_root : sq_side.dvs[i];
      ctlp_d.dzl[i] = ((ctlp_d.op == OP_DIV) || (ctlp_d.op == OP_SDIV) ||
                       (ctlp_d.op == OP_NORM)) && (dvp_d[i] == '0);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      p_ctl_q <= ctlp_d;
      p_n_q   <= sq_side.n;
      p_dv_q  <= dvp_d;
    end
  end

  // ---------------- divide ----------------
  vfa_div3 u_div3 (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (p_v_q),
    .n_i     (p_n_q),
    .d_i     (p_dv_q),
    .ctl_i   (p_ctl_q),
    .valid_o (dv_v),
    .q_o     (dv_q),
    .ov_o    (dv_ov),
    .ctl_o   (dv_ctl)
  );

  // ---------------- final select ----------------
  always_comb begin
    fvec = dv_ctl.vec;
    fsat = dv_ctl.sat;
    fdz  = 1'b0;
    if ((dv_ctl.op == OP_DIV) || (dv_ctl.op == OP_SDIV) || (dv_ctl.op == OP_NORM)) begin
      for (int i = 0; i < 3; i++) begin
        if (dv_ctl.dzl[i]) begin
          fdz = 1'b1;
          fvec[i] = dv_ctl.aneg[i] ? S32Min : (dv_ctl.azero[i] ? 32'd0 : S32Max);
        end else if (dv_ctl.qneg[i]) begin
          if (dv_ov[i] || (dv_q[i] > 32'h8000_0000)) begin
            fvec[i] = S32Min;
            fsat    = 1'b1;
          end else begin
            fvec[i] = (~dv_q[i]) + 32'd1;
          end
        end else begin
          if (dv_ov[i] || dv_q[i][31]) begin
            fvec[i] = S32Max;
            fsat    = 1'b1;
          end else begin
            fvec[i] = dv_q[i];
          end
        end
      end
    end
    rsp_d.r_x            = fvec[0];
    rsp_d.r_y            = fvec[1];
    rsp_d.r_z            = fvec[2];
    rsp_d.scalar_out     = dv_ctl.s;
    rsp_d.equal_flag     = dv_ctl.eq;
    rsp_d.saturated_flag = fsat;
    rsp_d.divide_by_zero = fdz;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_v_q <= 1'b0;
      skid_v_q <= 1'b0;
    end else begin
      if (en) begin
        last_v_q <= dv_v;
      end
      if (skid_v_q) begin
        if (out_ready_i) begin
          skid_v_q <= 1'b0;
        end
      end else if (last_v_q && !out_ready_i) begin
        skid_v_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      last_q <= rsp_d;
    end
    if (!skid_v_q && last_v_q && !out_ready_i) begin
      skid_q <= last_q;
    end
  end

  assign out_valid_o = skid_v_q | last_v_q;
  assign out_rsp_o   = skid_v_q ? skid_q : last_q;

  // ---------------- assertions ----------------
  `VFA_ASSERT(a_skid_fill,
    $rose(skid_v_q) |-> $past(last_v_q && !out_ready_i),
    "skid filled without a stalled result")
  `VFA_ASSERT_NEVER(a_dz_op,
    dv_v && (dv_ctl.dzl != 3'b000) && (dv_ctl.op != OP_DIV) &&
    (dv_ctl.op != OP_SDIV) && (dv_ctl.op != OP_NORM),
    "zero divisor on a non-dividing op")
  `VFA_ASSERT(a_eq_zero,
    out_valid_o && out_rsp_o.equal_flag |-> (out_rsp_o.r_x == 0) &&
    (out_rsp_o.r_y == 0) && (out_rsp_o.r_z == 0) && (out_rsp_o.scalar_out == 0),
    "equal flag with nonzero result")

endmodule
